@@ src/pks_pkg.sv @@
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types and constants for the polled key scanner with long press.
// ----------------------------------------------------------------------------
package pks_pkg;

    localparam int MASK_W   = 6;
    localparam int KEY_W    = 3;
    localparam int COUNT_W  = 2;
    localparam int THRESH_W = 16;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;

    localparam logic EVENT_HIT  = 1'b0;
    localparam logic EVENT_LONG = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_ENABLE    = 1'd1;

    typedef struct packed {
        logic long_cand;
        logic hit_cand;
        logic phase_zero;
    } t_lane_status;

    typedef struct packed {
        logic long_grant;
        logic hit_grant;
    } t_lane_grant;

    typedef struct packed {
        logic [COUNT_W-1:0] message_count;
        logic [KEY_W-1:0]   first_key;
        logic               first_event;
        logic [KEY_W-1:0]   second_key;
        logic               second_event;
        logic               beep;
    } t_result;

endpackage

@@ src/pks_in_if.sv @@
// ----------------------------------------------------------------------------
// pks_in_if
// Scan tick channel: pressed level of every key.
// ----------------------------------------------------------------------------
interface pks_in_if;

    logic                       valid;
    logic                       ready;
    logic [pks_pkg::MASK_W-1:0] pressed_mask;

    modport source (output valid, output pressed_mask, input ready);
    modport sink   (input valid, input pressed_mask, output ready);

endinterface

@@ src/pks_out_if.sv @@
// ----------------------------------------------------------------------------
// pks_out_if
// Key message channel: up to two messages and the beeper level per tick.
// ----------------------------------------------------------------------------
interface pks_out_if;

    logic                        valid;
    logic                        ready;
    logic [pks_pkg::COUNT_W-1:0] message_count;
    logic [pks_pkg::KEY_W-1:0]   first_key;
    logic                        first_event;
    logic [pks_pkg::KEY_W-1:0]   second_key;
    logic                        second_event;
    logic                        beep;

    modport source (output valid, output message_count, output first_key,
                    output first_event, output second_key, output second_event,
                    output beep, input ready);
    modport sink   (input valid, input message_count, input first_key,
                    input first_event, input second_key, input second_event,
                    input beep, output ready);

endinterface

@@ src/polled_key_scanner_long_press_top.sv @@
// ----------------------------------------------------------------------------
// polled_key_scanner_long_press_top
// Keypad scanner with hit reports and long-press repeat.
// ----------------------------------------------------------------------------
// Takes one scan tick per clock cycle and returns exactly one message set per
// tick, registered: the result of a tick is offered the cycle after its
// transfer, and a new tick is taken whenever the output register is empty or
// being drained. One lane per key updates its state in the transfer cycle and
// a single merge stage picks the long push or up to two hits. Configuration
// writes take effect on the next tick.
module polled_key_scanner_long_press_top #(
    parameter int KEY_COUNT    = 6,
    parameter int MAX_MESSAGES = 2,
    parameter int HOLD_WIDTH   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pks_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pks_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pks_in_if.sink                             i_in,
    pks_out_if.source                          o_out
);

    logic [pks_pkg::THRESH_W-1:0] r_threshold;
    logic                         r_beep_enable;
    logic                         r_valid;
    pks_pkg::t_result             r_result;

    logic                  accept;
    pks_pkg::t_lane_status status [KEY_COUNT];
    pks_pkg::t_lane_grant  grant  [KEY_COUNT];
    pks_pkg::t_result      n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= pks_pkg::THRESH_RESET;
            r_beep_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pks_pkg::REG_LONG_THRESHOLD: r_threshold <= i_cfg_data[pks_pkg::THRESH_W-1:0];
                pks_pkg::REG_BEEP_ENABLE:    r_beep_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
        logic pressed;
        if (k < pks_pkg::MASK_W) begin : g_used
            assign pressed = i_in.pressed_mask[k];
        end else begin : g_spare
            assign pressed = 1'b0;
        end
        pks_lane #(
            .HOLD_WIDTH (HOLD_WIDTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (accept),
            .i_pressed   (pressed),
            .i_threshold (r_threshold),
            .i_grant     (grant[k]),
            .o_status    (status[k])
        );
    end

    pks_merge #(
        .KEY_COUNT    (KEY_COUNT),
        .MAX_MESSAGES (MAX_MESSAGES)
    ) u_merge (
        .i_beep_enable (r_beep_enable),
        .i_status      (status),
        .o_grant       (grant),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.message_count = r_result.message_count;
    assign o_out.first_key     = r_result.first_key;
    assign o_out.first_event   = r_result.first_event;
    assign o_out.second_key    = r_result.second_key;
    assign o_out.second_event  = r_result.second_event;
    assign o_out.beep          = r_result.beep;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_result.message_count != 2'd3)
        else $error("message count out of range");

    a_beep_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.beep |->
            r_result.message_count != 2'd0 && r_result.first_event == pks_pkg::EVENT_HIT
            && r_beep_enable)
        else $error("beep without a reported hit");

    a_long_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.first_event == pks_pkg::EVENT_LONG |->
            r_result.message_count == 2'd1 && !r_result.beep)
        else $error("long push shares the tick with other messages");

    a_unused_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.message_count != 2'd2 |->
            r_result.second_key == '0 && r_result.second_event == 1'b0)
        else $error("unused message slot not zero");

endmodule

@@ src/pks_lane.sv @@
// ----------------------------------------------------------------------------
// pks_lane
// Per-key state: held flag, saturating hold counter, reported flag and
// repeat phase.
// ----------------------------------------------------------------------------
module pks_lane #(
    parameter int HOLD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_pressed,
    input  logic [pks_pkg::THRESH_W-1:0]     i_threshold,
    input  pks_pkg::t_lane_grant             i_grant,
    output pks_pkg::t_lane_status            o_status
);

    localparam int CMP_W = (HOLD_WIDTH > pks_pkg::THRESH_W) ? HOLD_WIDTH : pks_pkg::THRESH_W;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

    logic                        r_held;
    logic [HOLD_WIDTH-1:0]       r_count;
    logic                        r_reported;
    logic [pks_pkg::PHASE_W-1:0] r_phase;

    logic                        n_held;
    logic [HOLD_WIDTH-1:0]       n_count;
    logic                        n_reported;
    logic [pks_pkg::PHASE_W-1:0] n_phase;

    always_comb begin
        n_held = i_pressed;
        if (!i_pressed || !r_held) begin
            n_count = '0;
        end else if (r_count != HOLD_MAX) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
        n_reported = i_pressed && (r_reported || i_grant.hit_grant);
        if (i_grant.long_grant) begin
            n_phase = (r_phase == pks_pkg::PHASE_LAST) ? pks_pkg::PHASE_FIRST
                                                      : r_phase + 1'b1;
        end else if (i_grant.hit_grant) begin
            n_phase = pks_pkg::PHASE_FIRST;
        end else begin
            n_phase = r_phase;
        end
    end

    assign o_status.long_cand  = CMP_W'(n_count) > CMP_W'(i_threshold);
    assign o_status.hit_cand   = i_pressed && !r_reported;
    assign o_status.phase_zero = r_phase == pks_pkg::PHASE_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 1'b0;
            r_count    <= '0;
            r_reported <= 1'b0;
            r_phase    <= pks_pkg::PHASE_FIRST;
        end else if (i_en) begin
            r_held     <= n_held;
            r_count    <= n_count;
            r_reported <= n_reported;
            r_phase    <= n_phase;
        end
    end

endmodule

@@ src/pks_merge.sv @@
// ----------------------------------------------------------------------------
// pks_merge
// Combine lane findings: lowest long-push key wins, otherwise the lowest
// one or two unreported keys take a hit each.
// ----------------------------------------------------------------------------
module pks_merge #(
    parameter int KEY_COUNT    = 6,
    parameter int MAX_MESSAGES = 2
) (
    input  logic                  i_beep_enable,
    input  pks_pkg::t_lane_status i_status [KEY_COUNT],
    output pks_pkg::t_lane_grant  o_grant  [KEY_COUNT],
    output pks_pkg::t_result      o_result
);

    localparam bit TWO_SLOTS = MAX_MESSAGES >= 2;

    logic [KEY_COUNT-1:0] long_vec;
    logic [KEY_COUNT-1:0] hit_vec;
    logic [KEY_COUNT-1:0] phase_vec;
    logic [KEY_COUNT-1:0] long_sel;
    logic [KEY_COUNT-1:0] hit_sel1;
    logic [KEY_COUNT-1:0] hit_rest;
    logic [KEY_COUNT-1:0] hit_sel2;
    logic [KEY_COUNT-1:0] hit_grant;
    logic                 long_any;
    logic                 long_emit;
    logic                 hit1_any;
    logic                 hit2_any;
    logic [pks_pkg::KEY_W-1:0] long_key;
    logic [pks_pkg::KEY_W-1:0] hit1_key;
    logic [pks_pkg::KEY_W-1:0] hit2_key;

    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            long_vec[k]  = i_status[k].long_cand;
            hit_vec[k]   = i_status[k].hit_cand;
            phase_vec[k] = i_status[k].phase_zero;
        end
    end

    assign long_sel = long_vec & (~long_vec + 1'b1);
    assign long_any = |long_vec;
    assign long_emit = |(long_sel & phase_vec);

    assign hit_sel1 = hit_vec & (~hit_vec + 1'b1);
    assign hit_rest = hit_vec & ~hit_sel1;
    assign hit_sel2 = TWO_SLOTS ? (hit_rest & (~hit_rest + 1'b1)) : '0;
    assign hit_grant = long_any ? '0 : (hit_sel1 | hit_sel2);
    assign hit1_any = !long_any && (|hit_sel1);
    assign hit2_any = !long_any && (|hit_sel2);

    always_comb begin
        long_key = '0;
        hit1_key = '0;
        hit2_key = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (long_sel[k]) long_key = long_key | pks_pkg::KEY_W'(k);
            if (hit_sel1[k]) hit1_key = hit1_key | pks_pkg::KEY_W'(k);
            if (hit_sel2[k]) hit2_key = hit2_key | pks_pkg::KEY_W'(k);
        end
    end

    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            o_grant[k].long_grant = long_sel[k];
            o_grant[k].hit_grant  = hit_grant[k];
        end
    end

    always_comb begin
        o_result = '0;
        if (long_any) begin
            if (long_emit) begin
                o_result.message_count = pks_pkg::COUNT_W'(1);
                o_result.first_key     = long_key;
                o_result.first_event   = pks_pkg::EVENT_LONG;
            end
        end else if (hit1_any) begin
            o_result.first_key     = hit1_key;
            o_result.first_event   = pks_pkg::EVENT_HIT;
            o_result.beep          = i_beep_enable;
            if (hit2_any) begin
                o_result.message_count = pks_pkg::COUNT_W'(2);
                o_result.second_key    = hit2_key;
                o_result.second_event  = pks_pkg::EVENT_HIT;
            end else begin
                o_result.message_count = pks_pkg::COUNT_W'(1);
            end
        end
    end

endmodule
